// ----- rtl/core/ufp_pkg.sv -----
// Shared types, codes and defaults for the UBX frame parser.
package ufp_pkg;

   // Default payload buffer depth in bytes
   localparam int UFP_BUFFER_DEPTH = 256;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int OPCODE_W = 2;
   localparam int KIND_W   = 2;
   localparam int LEN_W    = 9;
   localparam int ERR_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_RX_BYTE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
   localparam logic [ERR_W-1:0] ERR_SYNC    = 3'd1;
   localparam logic [ERR_W-1:0] ERR_LONG    = 3'd2;
   localparam logic [ERR_W-1:0] ERR_CK_A    = 3'd3;
   localparam logic [ERR_W-1:0] ERR_CK_B    = 3'd4;
   localparam logic [ERR_W-1:0] ERR_OVERRUN = 3'd5;

   // Control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   // Control register reset values
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;
   localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 9'd255;

   // Parser phase: named after the byte expected next
   typedef enum logic [3:0] {
      P_HUNT,
      P_SYNC2,
      P_CLASS,
      P_ID,
      P_LEN_LO,
      P_LEN_HI,
      P_PAYLOAD,
      P_CK_A,
      P_CK_B
   } phase_type;

   // One request item
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   rx_byte;
      logic [BYTE_W-1:0]   read_index;
   } req_item_type;

   // One control register write
   typedef struct packed {
      logic                  en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   // Result item before the payload byte is merged in
   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [BYTE_W-1:0] frame_class;
      logic [BYTE_W-1:0] frame_id;
      logic [LEN_W-1:0]  frame_length;
      logic [ERR_W-1:0]  error_code;
      logic [BYTE_W-1:0] overrun_count;
      logic              data_hit;
   } rsp_item_type;

endpackage

// ----- rtl/core/ufp_if.sv -----
// Channel interfaces of the UBX frame parser: request, result and control writes.
interface ufp_req_if
   import ufp_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   rx_byte;
   logic [BYTE_W-1:0]   read_index;

   modport source (output valid, output opcode, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input opcode, input rx_byte, input read_index,
                   output ready);
endinterface

interface ufp_rsp_if
   import ufp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [BYTE_W-1:0] frame_class;
   logic [BYTE_W-1:0] frame_id;
   logic [LEN_W-1:0]  frame_length;
   logic [BYTE_W-1:0] read_data;
   logic [ERR_W-1:0]  error_code;
   logic [BYTE_W-1:0] overrun_count;

   modport source (output valid, output result_kind, output frame_class,
                   output frame_id, output frame_length, output read_data,
                   output error_code, output overrun_count, input ready);
   modport sink   (input valid, input result_kind, input frame_class,
                   input frame_id, input frame_length, input read_data,
                   input error_code, input overrun_count, output ready);
endinterface

interface ufp_csr_if
   import ufp_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ----- rtl/core/ubx_frame_parser_unit.sv -----
// Top level of the UBX frame parser: channels, parser control, payload store, result path.
//
//  channel   dir  handshake    payload
//  req_chan  in   valid/ready  opcode, rx_byte, read_index
//  rsp_chan  out  valid/ready  result_kind, frame_class, frame_id, frame_length,
//                              read_data, error_code, overrun_count
//  csr_chan  in   valid/ready  reg_index, write_data (always ready)
//
// One item per cycle while stage 1 is free or moving on. A result passes through stage 1
// and then the output register, where reads pick up the store's registered read data.
// While stage 1 holds a result that cannot move on, every item waits, result or not.
// Reset (synchronous) clears parser state, held flag, overrun counter, control
// registers and result valids; the payload store is not cleared.
// A stalled result channel holds up to two results before req_chan.ready drops.
module ubx_frame_parser_unit
   import ufp_pkg::*;
#(
   parameter int BUFFER_DEPTH = UFP_BUFFER_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   ufp_req_if.sink   req_chan,
   ufp_rsp_if.source rsp_chan,
   ufp_csr_if.sink   csr_chan
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   logic              accept;
   logic              can_accept;
   logic              push;
   req_item_type      req_item;
   csr_write_type     csr_wr;
   rsp_item_type      push_item;
   logic              mem_wr_en, mem_rd_en;
   logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
   logic [BYTE_W-1:0] mem_wr_data, mem_rd_data;

   // Request handshake
   assign req_chan.ready      = can_accept;
   assign accept              = req_chan.valid && can_accept;
   assign req_item.opcode     = req_chan.opcode;
   assign req_item.rx_byte    = req_chan.rx_byte;
   assign req_item.read_index = req_chan.read_index;

   // Control writes are always taken
   assign csr_chan.ready = 1'b1;
   assign csr_wr.en      = csr_chan.valid;
   assign csr_wr.index   = csr_chan.reg_index;
   assign csr_wr.data    = csr_chan.write_data;

   ufp_frame_ctl #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .AW           (AW)
   ) u_ctl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_item    (req_item),
      .csr_wr      (csr_wr),
      .push        (push),
      .rsp_item    (push_item),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr)
   );

   ufp_payload_ram #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ufp_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .rd_data    (mem_rd_data),
      .can_accept (can_accept),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- rtl/core/ufp_payload_ram.sv -----
// Payload byte store: one write port, one read port with registered read data.
module ufp_payload_ram
   import ufp_pkg::*;
#(
   parameter int DEPTH = UFP_BUFFER_DEPTH,
   parameter int AW    = $clog2(UFP_BUFFER_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ufp_frame_ctl.sv -----
// Frame parser control: phase machine, checksum, held message and control registers.
module ufp_frame_ctl
   import ufp_pkg::*;
#(
   parameter int BUFFER_DEPTH = UFP_BUFFER_DEPTH,
   parameter int AW           = $clog2(UFP_BUFFER_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  req_item_type      req_item,
   input  csr_write_type     csr_wr,
   output logic              push,
   output rsp_item_type      rsp_item,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output logic [BYTE_W-1:0] mem_wr_data,
   output logic              mem_rd_en,
   output logic [AW-1:0]     mem_rd_addr
);

   // Length / index width holds BUFFER_DEPTH itself
   localparam int LW = $clog2(BUFFER_DEPTH + 1);
   localparam int CW = (LW > BYTE_W) ? LW : BYTE_W;

   // Control registers
   logic [BYTE_W-1:0] sync_first_ff, sync_second_ff;
   logic [LEN_W-1:0]  max_payload_ff;

   // Parser state
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] class_ff, class_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [BYTE_W-1:0] len_lo_ff, len_lo_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [LW-1:0]     idx_ff, idx_in;
   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic              held_ff, held_in;
   logic [BYTE_W-1:0] drop_ff, drop_in;

   logic [BYTE_W-1:0] sum_a_step, sum_b_step;
   logic [15:0]       len_full;
   logic              too_long;
   logic [LW-1:0]     idx_next;
   logic              read_hit;

   // Control register writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         max_payload_ff <= MAX_PAYLOAD_RST;
      end else if (csr_wr.en) begin
         case (csr_wr.index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wr.data[BYTE_W-1:0];
            CSR_SYNC_SECOND: sync_second_ff <= csr_wr.data[BYTE_W-1:0];
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_wr.data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= P_HUNT;
         class_ff  <= '0;
         id_ff     <= '0;
         len_lo_ff <= '0;
         len_ff    <= '0;
         idx_ff    <= '0;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
         held_ff   <= 1'b0;
         drop_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         len_lo_ff <= len_lo_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         held_ff   <= held_in;
         drop_ff   <= drop_in;
      end
   end

   // Datapath terms
   assign sum_a_step = sum_a_ff + req_item.rx_byte;
   assign sum_b_step = sum_b_ff + sum_a_step;
   assign len_full   = {req_item.rx_byte, len_lo_ff};
   assign too_long   = (len_full > 16'(max_payload_ff)) || (len_full > 16'(BUFFER_DEPTH));
   assign idx_next   = idx_ff + 1'b1;
   assign read_hit   = held_ff && (CW'(req_item.read_index) < CW'(len_ff));

   // Memory ports
   assign mem_wr_addr = AW'(idx_ff);
   assign mem_wr_data = req_item.rx_byte;
   assign mem_rd_addr = AW'(req_item.read_index);

   // Next state and result
   always_comb begin
      phase_in  = phase_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      len_lo_in = len_lo_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      held_in   = held_ff;
      drop_in   = drop_ff;
      push      = 1'b0;
      rsp_item  = '0;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;

      if (accept) begin
         case (req_item.opcode)
            OP_RX_BYTE: begin
               // Checksum covers class, id, length and payload
               if (phase_ff == P_CLASS || phase_ff == P_ID || phase_ff == P_LEN_LO ||
                   phase_ff == P_LEN_HI || phase_ff == P_PAYLOAD) begin
                  sum_a_in = sum_a_step;
                  sum_b_in = sum_b_step;
               end
               case (phase_ff)
                  P_HUNT: begin
                     if (req_item.rx_byte == sync_first_ff) begin
                        phase_in = P_SYNC2;
                     end
                  end
                  P_SYNC2: begin
                     if (req_item.rx_byte != sync_second_ff) begin
                        phase_in             = P_HUNT;
                        push                 = 1'b1;
                        rsp_item.result_kind = KIND_REJECT;
                        rsp_item.error_code  = ERR_SYNC;
                     end else begin
                        sum_a_in = '0;
                        sum_b_in = '0;
                        phase_in = P_CLASS;
                     end
                  end
                  P_CLASS: begin
                     // New frame while a message is still held
                     if (held_ff) begin
                        drop_in              = drop_ff + 1'b1;
                        phase_in             = P_HUNT;
                        push                 = 1'b1;
                        rsp_item.result_kind = KIND_REJECT;
                        rsp_item.error_code  = ERR_OVERRUN;
                     end else begin
                        class_in = req_item.rx_byte;
                        phase_in = P_ID;
                     end
                  end
                  P_ID: begin
                     id_in    = req_item.rx_byte;
                     phase_in = P_LEN_LO;
                  end
                  P_LEN_LO: begin
                     len_lo_in = req_item.rx_byte;
                     phase_in  = P_LEN_HI;
                  end
                  P_LEN_HI: begin
                     if (too_long) begin
                        phase_in             = P_HUNT;
                        push                 = 1'b1;
                        rsp_item.result_kind = KIND_REJECT;
                        rsp_item.error_code  = ERR_LONG;
                     end else begin
                        len_in   = LW'(len_full);
                        idx_in   = '0;
                        // Empty payload goes straight to the checksum
                        phase_in = (len_full == '0) ? P_CK_A : P_PAYLOAD;
                     end
                  end
                  P_PAYLOAD: begin
                     mem_wr_en = 1'b1;
                     idx_in    = idx_next;
                     if (idx_next >= len_ff) begin
                        phase_in = P_CK_A;
                     end
                  end
                  P_CK_A: begin
                     if (req_item.rx_byte != sum_a_ff) begin
                        phase_in             = P_HUNT;
                        push                 = 1'b1;
                        rsp_item.result_kind = KIND_REJECT;
                        rsp_item.error_code  = ERR_CK_A;
                     end else begin
                        phase_in = P_CK_B;
                     end
                  end
                  P_CK_B: begin
                     phase_in = P_HUNT;
                     push     = 1'b1;
                     if (req_item.rx_byte != sum_b_ff) begin
                        rsp_item.result_kind = KIND_REJECT;
                        rsp_item.error_code  = ERR_CK_B;
                     end else begin
                        held_in               = 1'b1;
                        rsp_item.result_kind  = KIND_ACCEPT;
                        rsp_item.frame_class  = class_ff;
                        rsp_item.frame_id     = id_ff;
                        rsp_item.frame_length = LEN_W'(len_ff);
                        rsp_item.error_code   = ERR_NONE;
                     end
                  end
                  default: begin
                     phase_in = P_HUNT;
                  end
               endcase
            end
            OP_READ: begin
               push                 = 1'b1;
               rsp_item.result_kind = KIND_READ;
               rsp_item.error_code  = ERR_NONE;
               mem_rd_en            = read_hit;
               rsp_item.data_hit    = read_hit;
               if (held_ff) begin
                  rsp_item.frame_class  = class_ff;
                  rsp_item.frame_id     = id_ff;
                  rsp_item.frame_length = LEN_W'(len_ff);
               end
            end
            OP_RELEASE: begin
               held_in = 1'b0;
            end
            default: ;
         endcase
      end

      // Every result reports the counter after this item
      rsp_item.overrun_count = drop_in;
   end

   // A held message blocks the parser at the class byte, so no payload write can
   // reach the store while it is read
   a_held_phase: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> (phase_ff == P_HUNT || phase_ff == P_SYNC2 || phase_ff == P_CLASS))
      else $error("message held while a frame body is being parsed");

   a_wr_not_held: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !held_ff)
      else $error("payload write while a message is held");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_PAYLOAD) |-> (idx_ff < len_ff))
      else $error("payload index past frame length");

endmodule

// ----- rtl/core/ufp_rsp_queue.sv -----
// Two-entry result path: a stage that meets the read data, then the output register.
module ufp_rsp_queue
   import ufp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsp_item_type      push_item,
   input  logic [BYTE_W-1:0] rd_data,
   output logic              can_accept,
   ufp_rsp_if.source         rsp_chan
);

   logic              s1_v_ff, s1_v_in;
   rsp_item_type      s1_ff;
   logic              s2_v_ff, s2_v_in;
   rsp_item_type      s2_ff;
   logic [BYTE_W-1:0] s2_data_ff;
   logic              s1_move;

   // Stage 1 moves on when the output register is free or being taken
   assign s1_move    = s1_v_ff && (!s2_v_ff || rsp_chan.ready);
   assign can_accept = !s1_v_ff || s1_move;

   always_comb begin
      s1_v_in = s1_v_ff;
      if (push) begin
         s1_v_in = 1'b1;
      end else if (s1_move) begin
         s1_v_in = 1'b0;
      end
      s2_v_in = s2_v_ff;
      if (s1_move) begin
         s2_v_in = 1'b1;
      end else if (rsp_chan.ready) begin
         s2_v_in = 1'b0;
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (push) begin
         s1_ff <= push_item;
      end
      if (s1_move) begin
         s2_ff      <= s1_ff;
         s2_data_ff <= s1_ff.data_hit ? rd_data : '0;
      end
   end

   // Output channel
   assign rsp_chan.valid         = s2_v_ff;
   assign rsp_chan.result_kind   = s2_ff.result_kind;
   assign rsp_chan.frame_class   = s2_ff.frame_class;
   assign rsp_chan.frame_id      = s2_ff.frame_id;
   assign rsp_chan.frame_length  = s2_ff.frame_length;
   assign rsp_chan.read_data     = s2_data_ff;
   assign rsp_chan.error_code    = s2_ff.error_code;
   assign rsp_chan.overrun_count = s2_ff.overrun_count;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> can_accept)
      else $error("result pushed with stage 1 occupied");

   a_rd_stable: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s1_ff.data_hit && !s1_move) |=> $stable(rd_data))
      else $error("read data changed under a waiting read item");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> s2_v_ff)
      else $error("output register empty after stage 1 moved");

endmodule
